>>> rtl/core/cfpr_pkg.sv
// cfpr_pkg: shared types, constants and the crc-16/modbus byte update
// for the framed packet receiver; no dependencies
package cfpr_pkg;

  localparam logic [7:0]  HDR1     = 8'hAA;
  localparam logic [7:0]  HDR2     = 8'h55;
  localparam logic [7:0]  TAIL     = 8'h0D;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int          MIN_LEN  = 7;
  localparam int          LEN_W    = 8;
  localparam int          CNT_W    = 6;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_LEN,
    PH_CMD,
    PH_DATA,
    PH_CRCLO,
    PH_CRCHI,
    PH_TAIL
  } phase_t;

  // one accepted frame waiting to be emitted
  typedef struct packed {
    logic [7:0]       cmd;
    logic [LEN_W-1:0] plen;
  } desc_t;

  // descriptor queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/cfpr_ram.sv
// cfpr_ram: generic single-write, single-read ram with registered read
// no dependencies
module cfpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/cfpr_front.sv
// cfpr_front: header hunt, length/crc/tail checks, payload write into the
// current ram bank; depends on cfpr_pkg
module cfpr_front import cfpr_pkg::*; #(
  parameter int MAX_LEN = 64,
  parameter int IDX_W   = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_rx_byte,
  output logic             in_stall,
  input  q_stat_t          q_stat,
  output logic             push,
  output desc_t            push_desc,
  output logic             ram_we,
  output logic [IDX_W:0]   ram_waddr,
  output logic [7:0]       ram_wdata
);

  localparam int DEPTH = MAX_LEN - MIN_LEN;

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] flen_r, flen_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       crclo_r, crclo_nxt;
  logic             bank_r, bank_nxt;

  logic             take;
  logic [7:0]       b;
  logic [LEN_W-1:0] plen;
  phase_t           drop_ph;

  assign in_stall = q_stat.full;
  assign take     = in_valid && !in_stall;
  assign b        = in_rx_byte;
  assign plen     = flen_r - LEN_W'(MIN_LEN);
  assign drop_ph  = (b == HDR1) ? PH_HUNT2 : PH_HUNT1;

  always_comb begin
    phase_nxt = phase_r;
    flen_nxt  = flen_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    crc_nxt   = crc_r;
    crclo_nxt = crclo_r;
    bank_nxt  = bank_r;
    push      = 1'b0;
    push_desc = '{cmd: cmd_r, plen: plen};
    ram_we    = 1'b0;
    ram_waddr = {bank_r, cnt_r[IDX_W-1:0]};
    ram_wdata = b;
    if (take) begin
      unique case (phase_r)
        PH_HUNT1: begin
          if (b == HDR1) phase_nxt = PH_HUNT2;
        end
        PH_HUNT2: begin
          phase_nxt = (b == HDR2) ? PH_LEN : drop_ph;
        end
        PH_LEN: begin
          if (b >= 8'(MIN_LEN) && b <= 8'(MAX_LEN)) begin
            flen_nxt  = b;
            cnt_nxt   = '0;
            crc_nxt   = crc_update(CRC_INIT, b);
            phase_nxt = PH_CMD;
          end else begin
            phase_nxt = drop_ph;
          end
        end
        PH_CMD: begin
          cmd_nxt   = b;
          crc_nxt   = crc_update(crc_r, b);
          phase_nxt = (flen_r == LEN_W'(MIN_LEN)) ? PH_CRCLO : PH_DATA;
        end
        PH_DATA: begin
          ram_we  = (cnt_r < LEN_W'(DEPTH));
          cnt_nxt = cnt_r + 1'b1;
          crc_nxt = crc_update(crc_r, b);
          if (cnt_nxt >= plen) phase_nxt = PH_CRCLO;
        end
        PH_CRCLO: begin
          crclo_nxt = b;
          phase_nxt = PH_CRCHI;
        end
        PH_CRCHI: begin
          phase_nxt = (crc_r == {b, crclo_r}) ? PH_TAIL : drop_ph;
        end
        PH_TAIL: begin
          if (b != TAIL) begin
            phase_nxt = drop_ph;
          end else begin
            push      = 1'b1;
            bank_nxt  = ~bank_r;
            phase_nxt = PH_HUNT1;
          end
        end
        default: phase_nxt = PH_HUNT1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      flen_r  <= '0;
      cnt_r   <= '0;
      cmd_r   <= '0;
      crc_r   <= CRC_INIT;
      crclo_r <= '0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      flen_r  <= flen_nxt;
      cnt_r   <= cnt_nxt;
      cmd_r   <= cmd_nxt;
      crc_r   <= crc_nxt;
      crclo_r <= crclo_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

>>> rtl/core/cfpr_queue.sv
// cfpr_queue: two-entry descriptor queue between front and back
// depends on cfpr_pkg
module cfpr_queue import cfpr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  desc_t   push_desc,
  input  logic    pop,
  output desc_t   head,
  output q_stat_t q_stat
);

  desc_t      entry_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;

  assign head         = entry_r[rptr_r];
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/core/cfpr_back.sv
// cfpr_back: walks the head frame's payload out of the ram, one result per cycle
// unless out_stall holds it, using the ram read register as the output stage; depends on cfpr_pkg
module cfpr_back import cfpr_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  desc_t            head,
  input  q_stat_t          q_stat,
  output logic             pop,
  output logic             ram_re,
  output logic [IDX_W:0]   ram_raddr,
  input  logic [7:0]       ram_rdata,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_command,
  output logic [7:0]       out_payload_byte,
  output logic             out_has_data,
  output logic [CNT_W-1:0] out_payload_count,
  output logic             out_last
);

  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             bank_r, bank_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic             has_r, has_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             last_r, last_nxt;

  logic advance, emit, is_last, nonzero;

  assign advance   = !(valid_r && out_stall);
  assign emit      = advance && !q_stat.empty;
  assign nonzero   = (head.plen != '0);
  assign is_last   = !nonzero || (idx_r == head.plen - 1'b1);
  assign pop       = emit && is_last;
  assign ram_re    = emit && nonzero;
  assign ram_raddr = {bank_r, idx_r[IDX_W-1:0]};

  always_comb begin
    idx_nxt   = idx_r;
    bank_nxt  = bank_r;
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    has_nxt   = has_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    if (advance) begin
      valid_nxt = !q_stat.empty;
      cmd_nxt   = head.cmd;
      has_nxt   = nonzero;
      count_nxt = head.plen[CNT_W-1:0];
      last_nxt  = is_last;
    end
    if (emit) begin
      idx_nxt = is_last ? '0 : idx_r + 1'b1;
      if (is_last) bank_nxt = ~bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      bank_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      bank_r  <= bank_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    has_r   <= has_nxt;
    count_r <= count_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid         = valid_r;
  assign out_command       = cmd_r;
  assign out_has_data      = has_r;
  assign out_payload_byte  = has_r ? ram_rdata : 8'h00;
  assign out_payload_count = count_r;
  assign out_last          = last_r;

endmodule

>>> rtl/core/crc16_framed_packet_receiver.sv
// crc16_framed_packet_receiver: top level, front parser, descriptor queue,
// back emitter and a two-bank payload ram; depends on cfpr_pkg and all cfpr modules
//
// receives one byte per item and finds frames of the form aa 55, len, cmd,
// payload (len-7 bytes), crc low, crc high, 0d, with len in 7..MAX_LEN and a
// crc-16/modbus over len, cmd and payload. a good frame gives one result per
// payload byte (last marks the final one), or a single result with has_data
// clear when the payload is empty; a bad frame is dropped without a trace and
// the offending byte is rechecked as a header start. the front takes one byte
// every cycle, its crc update done within that cycle; it stalls only while two
// good frames are still waiting to be emitted, since the payload ram holds two
// banks. the back emits one result per cycle while out_stall is low, straight
// from the ram read register; a frame's tail byte reaches its first result
// through the descriptor queue and the ram read register, and emission of one
// frame overlaps reception of the next.
module crc16_framed_packet_receiver import cfpr_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_rx_byte,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_command,
  output logic [7:0]       out_payload_byte,
  output logic             out_has_data,
  output logic [CNT_W-1:0] out_payload_count,
  output logic             out_last
);

  // payload bytes per bank, and index bits inside a bank
  localparam int DEPTH = MAX_LEN - MIN_LEN;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // queue handshake between front and back
  logic    q_push, q_pop;
  desc_t   q_in, q_head;
  q_stat_t q_stat;

  // ram ports, bank bit on top of the address
  logic           ram_we, ram_re;
  logic [IDX_W:0] ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  cfpr_front #(
    .MAX_LEN (MAX_LEN),
    .IDX_W   (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_desc  (q_in),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  cfpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .q_stat    (q_stat)
  );

  // two banks, each a power of two deep
  cfpr_ram #(
    .WIDTH (8),
    .DEPTH (2 << IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cfpr_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .q_stat            (q_stat),
    .pop               (q_pop),
    .ram_re            (ram_re),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_command       (out_command),
    .out_payload_byte  (out_payload_byte),
    .out_has_data      (out_has_data),
    .out_payload_count (out_payload_count),
    .out_last          (out_last)
  );

  // back never retires a frame that is not queued
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("frame popped from empty queue");

  // front never completes a frame while both banks are taken
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("frame pushed into full queue");

  // payload writes never hit the location being read out
  a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr[IDX_W] != ram_raddr[IDX_W]))
    else $error("front and back share a payload bank");

  // an empty-payload result is always the only result of its frame
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_data) |-> (out_last && out_payload_count == '0))
    else $error("empty frame result not marked last");

endmodule

>>> dv/testbench.sv
// testbench: self-checking bench for crc16_framed_packet_receiver; drives byte
// streams of good, broken and noisy frames and checks every emitted result item
// depends on cfpr_pkg and the rtl top level only
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cfpr_pkg::*;

  localparam int MAX_FRAME     = 64;                  // matches the dut default
  localparam int PAYLOAD_MAX   = MAX_FRAME - MIN_LEN; // 57 bytes
  localparam int DRAIN_CYCLES  = 20000;               // bound on the final wait
  localparam int SETTLE_CYCLES = 30;                  // tail latency plus margin

  typedef logic [7:0] byte_q_t[$];

  // one emitted result as the block should present it
  typedef struct {
    logic [7:0]       command;
    logic [7:0]       payload_byte;
    logic             has_data;
    logic [CNT_W-1:0] payload_count;
    logic             last;
  } frame_result_t;

  // kinds of stimulus chunks in the random traffic
  typedef enum int {
    FR_GOOD,
    FR_BAD_LEN,
    FR_BAD_CRC,
    FR_BAD_TAIL,
    FR_NOISE,
    FR_CUT
  } frame_kind_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             in_stall;
  logic             out_valid;
  logic             out_stall  = 1'b0;
  logic [7:0]       out_command;
  logic [7:0]       out_payload_byte;
  logic             out_has_data;
  logic [CNT_W-1:0] out_payload_count;
  logic             out_last;

  // idling switches, changed only at test or test phase boundaries
  bit in_idle  = 1'b1;
  bit out_idle = 1'b1;

  // expected result items in arrival order
  frame_result_t pending_results[$];

  int error_count     = 0;
  int bytes_sent      = 0;
  int results_checked = 0;
  int frames_accepted = 0;
  int frames_dropped  = 0;

  // receiver shadow state, tracks the dut byte by byte
  phase_t      rx_phase  = PH_HUNT1;
  logic [7:0]  rx_len    = 8'h00;
  logic [7:0]  rx_count  = 8'h00;
  logic [7:0]  rx_cmd    = 8'h00;
  logic [7:0]  rx_crc_lo = 8'h00;
  logic [15:0] rx_crc    = CRC_INIT;
  logic [7:0]  rx_payload [PAYLOAD_MAX];

  crc16_framed_packet_receiver #(
    .MAX_LEN(MAX_FRAME)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_rx_byte       (in_rx_byte),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_payload_byte (out_payload_byte),
    .out_has_data     (out_has_data),
    .out_payload_count(out_payload_count),
    .out_last         (out_last)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // bit-serial crc-16/modbus: shift out lsb, fold in poly when feedback is set
  function automatic logic [15:0] modbus_crc_step(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // full frame bytes; crc_flip and tail_b let callers break a frame on purpose
  function automatic byte_q_t make_frame(input logic [7:0] len_b, input logic [7:0] cmd,
                                         input byte_q_t payload, input logic [15:0] crc_flip,
                                         input logic [7:0] tail_b);
    byte_q_t     q;
    logic [15:0] c;
    c = modbus_crc_step(CRC_INIT, len_b);
    c = modbus_crc_step(c, cmd);
    foreach (payload[i]) c = modbus_crc_step(c, payload[i]);
    c = c ^ crc_flip;
    q.push_back(HDR1);
    q.push_back(HDR2);
    q.push_back(len_b);
    q.push_back(cmd);
    q = {q, payload};
    q.push_back(c[7:0]);   // crc goes low byte first
    q.push_back(c[15:8]);
    q.push_back(tail_b);
    return q;
  endfunction

  function automatic byte_q_t random_payload(input int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // a failed frame falls back to the hunt; the failing byte may start a header
  task automatic drop_frame(input logic [7:0] b);
    rx_phase = (b == HDR1) ? PH_HUNT2 : PH_HUNT1;
    frames_dropped++;
  endtask

  // advance the shadow receiver by one byte and queue any results it causes
  task automatic track_rx_byte(input logic [7:0] b);
    int            plen;
    frame_result_t r;
    case (rx_phase)
      PH_HUNT1: begin
        if (b == HDR1) rx_phase = PH_HUNT2;
      end
      PH_HUNT2: begin
        // a repeated 0xaa keeps us waiting for 0x55
        if (b == HDR2) rx_phase = PH_LEN;
        else drop_frame(b);
      end
      PH_LEN: begin
        if (b >= MIN_LEN && b <= MAX_FRAME) begin
          rx_len   = b;
          rx_count = 8'h00;
          rx_crc   = modbus_crc_step(CRC_INIT, b);
          rx_phase = PH_CMD;
        end else begin
          drop_frame(b);
        end
      end
      PH_CMD: begin
        rx_cmd   = b;
        rx_crc   = modbus_crc_step(rx_crc, b);
        rx_phase = (rx_len == MIN_LEN) ? PH_CRCLO : PH_DATA;
      end
      PH_DATA: begin
        rx_payload[rx_count] = b;
        rx_count             = rx_count + 8'd1;
        rx_crc               = modbus_crc_step(rx_crc, b);
        if (rx_count >= rx_len - MIN_LEN) rx_phase = PH_CRCLO;
      end
      PH_CRCLO: begin
        rx_crc_lo = b;
        rx_phase  = PH_CRCHI;
      end
      PH_CRCHI: begin
        // crc is judged on the high byte, before the tail shows up
        if (rx_crc == {b, rx_crc_lo}) rx_phase = PH_TAIL;
        else drop_frame(b);
      end
      PH_TAIL: begin
        if (b != TAIL) begin
          drop_frame(b);
        end else begin
          plen            = rx_len - MIN_LEN;
          r.command       = rx_cmd;
          r.payload_count = CNT_W'(plen);
          if (plen == 0) begin
            r.payload_byte = 8'h00;
            r.has_data     = 1'b0;
            r.last         = 1'b1;
            pending_results.push_back(r);
          end else begin
            for (int k = 0; k < plen; k++) begin
              r.payload_byte = rx_payload[k];
              r.has_data     = 1'b1;
              r.last         = (k == plen - 1);
              pending_results.push_back(r);
            end
          end
          frames_accepted++;
          rx_phase = PH_HUNT1;
        end
      end
      default: rx_phase = PH_HUNT1;
    endcase
  endtask

  // offer one byte from a falling edge, hold it until taken, return at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    track_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // sender holds off until every queued result has come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // empty payload, stray header byte, and a two-byte payload of extreme byte values
  task automatic test_short_frames();
    byte_q_t none;
    byte_q_t pl;
    in_idle  = 1'b1;
    out_idle = 1'b1;
    send_bytes(make_frame(8'd7, 8'h00, none, 16'h0000, TAIL));
    // extra 0xaa ahead of the 0x55 must not lose the frame
    send_byte(HDR1);
    pl = {8'h00, 8'hFF};
    send_bytes(make_frame(8'd9, 8'hFF, pl, 16'h0000, TAIL));
  endtask

  // length out of range, crc mismatch, wrong tail and restart on the failing byte
  task automatic test_drop_and_resync();
    byte_q_t none;
    byte_q_t q;
    send_bytes({HDR1, HDR2, 8'd6});                     // one below the minimum
    send_bytes({HDR1, HDR2, 8'(MAX_FRAME + 1)});        // one above the maximum
    send_bytes(make_frame(8'd7, 8'h5A, none, 16'h0100, TAIL));
    // tail replaced by 0xaa: the same byte starts the next header
    send_bytes(make_frame(8'd7, 8'h3C, none, 16'h0000, HDR1));
    q = make_frame(8'd7, 8'hC3, none, 16'h0000, TAIL);
    void'(q.pop_front());
    send_bytes(q);
  endtask

  // largest frame sent at full rate into an idling result side
  task automatic test_largest_frames();
    byte_q_t pl;
    in_idle  = 1'b0;
    out_idle = 1'b1;
    pl       = random_payload(PAYLOAD_MAX);
    pl[0]    = 8'h00;
    pl[PAYLOAD_MAX-1] = 8'hFF;
    send_bytes(make_frame(8'(MAX_FRAME), 8'hA5, pl, 16'h0000, TAIL));
  endtask

  // one chunk of random traffic: mostly good frames, the rest broken or noise
  task automatic send_random_chunk();
    frame_kind_t kind;
    int          pick;
    int          plen;
    int          keep;
    logic [7:0]  len_b;
    logic [7:0]  tail_b;
    logic [15:0] flip;
    byte_q_t     q;
    pick   = $urandom_range(0, 10);
    kind   = (pick < 6) ? FR_GOOD : frame_kind_t'(pick - 5);
    // small payloads keep the stream short
    plen   = $urandom_range(0, 6);
    len_b  = 8'(plen + MIN_LEN);
    flip   = 16'h0000;
    tail_b = TAIL;
    case (kind)
      FR_BAD_LEN: begin
        len_b = $urandom_range(0, 1) ? 8'($urandom_range(0, MIN_LEN - 1))
                                     : 8'($urandom_range(MAX_FRAME + 1, 255));
      end
      FR_BAD_CRC: flip = 16'($urandom_range(1, 16'hFFFF));
      FR_BAD_TAIL: begin
        tail_b = $urandom_range(0, 1) ? HDR1 : 8'($urandom_range(0, 255));
        if (tail_b == TAIL) tail_b = ~TAIL;
      end
      default: ;
    endcase
    if (kind == FR_NOISE) begin
      // header bytes are favored so the noise often looks like a frame start
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(0, 3);
        q.push_back(pick == 0 ? HDR1 : pick == 1 ? HDR2 : 8'($urandom_range(0, 255)));
      end
    end else begin
      q = make_frame(len_b, 8'($urandom_range(0, 255)), random_payload(plen), flip, tail_b);
      if (kind == FR_CUT) begin
        keep = $urandom_range(1, q.size() - 1);
        while (q.size() > keep) void'(q.pop_back());
      end
    end
    send_bytes(q);
  endtask

  task automatic test_random_traffic();
    int mark;
    // idling on both sides
    in_idle  = 1'b1;
    out_idle = 1'b1;
    mark     = bytes_sent;
    while (bytes_sent - mark < 10) send_random_chunk();
    wait_for_results();
    // full rate, no idling anywhere
    in_idle  = 1'b0;
    out_idle = 1'b0;
    mark     = bytes_sent;
    while (bytes_sent - mark < 8) send_random_chunk();
    // fast sender against a slow receiver fills the frame queue
    out_idle = 1'b1;
    mark     = bytes_sent;
    while (bytes_sent - mark < 8) send_random_chunk();
  endtask

  // result side stall: a fresh wait is drawn for each result item
  always begin : result_backpressure
    int hold;
    @(negedge clk);
    hold = out_idle ? $urandom_range(0, 19) : 0;
    if (hold > 0) begin
      out_stall <= 1'b1;
      repeat (hold) @(negedge clk);
    end
    out_stall <= 1'b0;
    do @(posedge clk); while (!(out_valid && !out_stall));
  end

  // compare every taken result item with the oldest expectation
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, cmd %02h byte %02h",
                                  out_command, out_payload_byte));
      end else begin
        want = pending_results.pop_front();
        if (out_command !== want.command)
          report_mismatch($sformatf("command %02h, want %02h", out_command, want.command));
        if (out_payload_byte !== want.payload_byte)
          report_mismatch($sformatf("payload_byte %02h, want %02h",
                                    out_payload_byte, want.payload_byte));
        if (out_has_data !== want.has_data)
          report_mismatch($sformatf("has_data %b, want %b", out_has_data, want.has_data));
        if (out_payload_count !== want.payload_count)
          report_mismatch($sformatf("payload_count %0d, want %0d",
                                    out_payload_count, want.payload_count));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_last, want.last));
        results_checked++;
      end
    end
  end

  // main sequence
  initial begin : run_tests
    int waited;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_short_frames();
    test_drop_and_resync();
    test_largest_frames();
    test_random_traffic();

    // let the back end empty, bounded so a lost result still ends the run
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending_results.size() != 0 && waited < DRAIN_CYCLES);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never came", pending_results.size()));

    $display("run covered %0d input bytes: %0d frames accepted, %0d drops or restarts",
             bytes_sent, frames_accepted, frames_dropped);
    $display("%0d result items checked, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("PASS crc16_framed_packet_receiver");
    end else begin
      $display("FAIL crc16_framed_packet_receiver");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #1000000;
    $display("timeout waiting for the block");
    $display("FAIL crc16_framed_packet_receiver");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cfpr_pkg.sv
rtl/core/cfpr_ram.sv
rtl/core/cfpr_front.sv
rtl/core/cfpr_queue.sv
rtl/core/cfpr_back.sv
rtl/core/crc16_framed_packet_receiver.sv
dv/testbench.sv
